>>> hdl/ott_pkg.sv
// ----------------------------------------------------------------------------
// ott_pkg
// Types, sizes and codes shared by the one-shot timer table modules.
// ----------------------------------------------------------------------------
package ott_pkg;

   localparam int SLOTS       = 8;
   localparam int MAX_RESULTS = 8;

   localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W  = $clog2(SLOTS + 1);
   localparam int NRES_W = $clog2(MAX_RESULTS + 1);

   localparam int HANDLE_W = 8;
   localparam int TIME_W   = 32;
   localparam int ENTRY_W  = HANDLE_W + TIME_W;

   localparam logic [1:0] MODE_TICK   = 2'd0;
   localparam logic [1:0] MODE_CREATE = 2'd1;
   localparam logic [1:0] MODE_DELETE = 2'd2;

   localparam logic [1:0] KIND_CREATE = 2'd0;
   localparam logic [1:0] KIND_DELETE = 2'd1;
   localparam logic [1:0] KIND_EXPIRE = 2'd2;

   typedef struct packed {
      logic [HANDLE_W-1:0] handle;
      logic [TIME_W-1:0]   deadline;
   } entry_type;

   typedef struct packed {
      logic [1:0]          kind;
      logic                accepted;
      logic [HANDLE_W-1:0] handle;
      logic [2:0]          slot;
      logic                last;
   } rsp_type;

   function automatic logic [2:0] slot_code(input logic [IDX_W-1:0] idx);
      return 3'(idx);
   endfunction

endpackage

>>> hdl/ott_ram.sv
// ----------------------------------------------------------------------------
// ott_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ott_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/ott_out.sv
// ----------------------------------------------------------------------------
// ott_out
// Result output register; takes a new result in the cycle the old one leaves.
// ----------------------------------------------------------------------------
module ott_out
   import ott_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  rsp_type             push_rsp,
   output logic                out_free,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [1:0]          rsp_kind,
   output logic                rsp_accepted,
   output logic [HANDLE_W-1:0] rsp_handle_out,
   output logic [2:0]          rsp_slot_out,
   output logic                rsp_last
);

   logic    vld_ff, vld_in;
   rsp_type data_ff;

   assign out_free = !vld_ff || rsp_ready;
   assign vld_in   = push || (vld_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         data_ff <= push_rsp;
      end
   end

   assign rsp_valid      = vld_ff;
   assign rsp_kind       = data_ff.kind;
   assign rsp_accepted   = data_ff.accepted;
   assign rsp_handle_out = data_ff.handle;
   assign rsp_slot_out   = data_ff.slot;
   assign rsp_last       = data_ff.last;

endmodule

>>> hdl/ott_ctrl.sv
// ----------------------------------------------------------------------------
// ott_ctrl
// Request sequencer: busy flags, uptime, slot scan over the entry RAM and
// result generation with one-result lookahead for the last flag.
// ----------------------------------------------------------------------------
module ott_ctrl
   import ott_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_mode,
   input  logic [HANDLE_W-1:0] req_timer_handle,
   input  logic [TIME_W-1:0]   req_period,
   output logic                ram_wr_en,
   output logic [IDX_W-1:0]    ram_wr_addr,
   output logic [ENTRY_W-1:0]  ram_wr_data,
   output logic                ram_rd_en,
   output logic [IDX_W-1:0]    ram_rd_addr,
   input  logic [ENTRY_W-1:0]  ram_rd_data,
   output logic                push,
   output rsp_type             push_rsp,
   input  logic                out_free
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_CREATE = 2'd1;
   localparam logic [1:0] ST_SCAN   = 2'd2;
   localparam logic [1:0] ST_FLUSH  = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic [1:0]          mode_ff, mode_in;
   logic [HANDLE_W-1:0] handle_ff, handle_in;
   logic [TIME_W-1:0]   period_ff, period_in;
   logic [TIME_W-1:0]   uptime_ff, uptime_in;
   logic [SLOTS-1:0]    busy_ff, busy_in;
   logic [CNT_W-1:0]    scan_idx_ff, scan_idx_in;
   logic                chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0]    chk_idx_ff, chk_idx_in;
   logic                found_ff, found_in;
   logic                hold_vld_ff, hold_vld_in;
   logic [HANDLE_W-1:0] hold_handle_ff, hold_handle_in;
   logic [IDX_W-1:0]    hold_idx_ff, hold_idx_in;
   logic [NRES_W-1:0]   nres_ff, nres_in;

   entry_type           rd_entry;
   entry_type           wr_entry;
   logic                free_any;
   logic [IDX_W-1:0]    free_idx;
   logic                hit;
   logic                stall;
   logic                is_tick;

   assign req_ready = (state_ff == ST_IDLE);
   assign rd_entry  = entry_type'(ram_rd_data);
   assign is_tick   = (mode_ff == MODE_TICK);

   always_comb begin
      free_any = 1'b0;
      free_idx = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!busy_ff[i]) begin
            free_any = 1'b1;
            free_idx = IDX_W'(i);
         end
      end
   end

   always_comb begin
      if (is_tick) begin
         hit = busy_ff[chk_idx_ff] && (rd_entry.deadline == uptime_ff) &&
               (nres_ff < NRES_W'(MAX_RESULTS));
      end else begin
         hit = busy_ff[chk_idx_ff] && (rd_entry.handle == handle_ff);
      end
   end

   assign stall = chk_vld_ff && hit && is_tick && hold_vld_ff && !out_free;

   assign wr_entry.handle   = handle_ff;
   assign wr_entry.deadline = uptime_ff + period_ff;
   assign ram_wr_addr       = free_idx;
   assign ram_wr_data       = wr_entry;
   assign ram_rd_addr       = scan_idx_ff[IDX_W-1:0];

   always_comb begin
      state_in       = state_ff;
      mode_in        = mode_ff;
      handle_in      = handle_ff;
      period_in      = period_ff;
      uptime_in      = uptime_ff;
      busy_in        = busy_ff;
      scan_idx_in    = scan_idx_ff;
      chk_vld_in     = chk_vld_ff;
      chk_idx_in     = chk_idx_ff;
      found_in       = found_ff;
      hold_vld_in    = hold_vld_ff;
      hold_handle_in = hold_handle_ff;
      hold_idx_in    = hold_idx_ff;
      nres_in        = nres_ff;
      push           = 1'b0;
      push_rsp       = '0;
      ram_wr_en      = 1'b0;
      ram_rd_en      = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               mode_in     = req_mode;
               handle_in   = req_timer_handle;
               period_in   = req_period;
               scan_idx_in = '0;
               chk_vld_in  = 1'b0;
               found_in    = 1'b0;
               hold_vld_in = 1'b0;
               nres_in     = '0;
               case (req_mode) inside
                  MODE_CREATE:             state_in = ST_CREATE;
                  MODE_TICK, MODE_DELETE:  state_in = ST_SCAN;
                  default:                 state_in = ST_IDLE;
               endcase
            end
         end
         ST_CREATE: begin
            if (out_free) begin
               push            = 1'b1;
               push_rsp.kind   = KIND_CREATE;
               push_rsp.handle = handle_ff;
               push_rsp.last   = 1'b1;
               if (free_any) begin
                  push_rsp.accepted = 1'b1;
                  push_rsp.slot     = slot_code(free_idx);
                  ram_wr_en         = 1'b1;
                  busy_in[free_idx] = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (!stall) begin
               if (chk_vld_ff && hit) begin
                  busy_in[chk_idx_ff] = 1'b0;
                  if (is_tick) begin
                     if (hold_vld_ff) begin
                        push              = 1'b1;
                        push_rsp.kind     = KIND_EXPIRE;
                        push_rsp.accepted = 1'b1;
                        push_rsp.handle   = hold_handle_ff;
                        push_rsp.slot     = slot_code(hold_idx_ff);
                     end
                     hold_vld_in    = 1'b1;
                     hold_handle_in = rd_entry.handle;
                     hold_idx_in    = chk_idx_ff;
                     nres_in        = nres_ff + NRES_W'(1);
                  end else begin
                     found_in = 1'b1;
                  end
               end
               if (scan_idx_ff < CNT_W'(SLOTS)) begin
                  ram_rd_en   = 1'b1;
                  chk_vld_in  = 1'b1;
                  chk_idx_in  = scan_idx_ff[IDX_W-1:0];
                  scan_idx_in = scan_idx_ff + CNT_W'(1);
               end else begin
                  chk_vld_in = 1'b0;
                  state_in   = ST_FLUSH;
               end
            end
         end
         ST_FLUSH: begin
            if (is_tick) begin
               if (!hold_vld_ff || out_free) begin
                  if (hold_vld_ff) begin
                     push              = 1'b1;
                     push_rsp.kind     = KIND_EXPIRE;
                     push_rsp.accepted = 1'b1;
                     push_rsp.handle   = hold_handle_ff;
                     push_rsp.slot     = slot_code(hold_idx_ff);
                     push_rsp.last     = 1'b1;
                  end
                  hold_vld_in = 1'b0;
                  uptime_in   = uptime_ff + TIME_W'(1);
                  state_in    = ST_IDLE;
               end
            end else if (out_free) begin
               push              = 1'b1;
               push_rsp.kind     = KIND_DELETE;
               push_rsp.accepted = found_ff;
               push_rsp.handle   = handle_ff;
               push_rsp.last     = 1'b1;
               state_in          = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         uptime_ff   <= '0;
         busy_ff     <= '0;
         chk_vld_ff  <= 1'b0;
         hold_vld_ff <= 1'b0;
         found_ff    <= 1'b0;
         scan_idx_ff <= '0;
         nres_ff     <= '0;
         mode_ff     <= MODE_TICK;
      end else begin
         state_ff    <= state_in;
         uptime_ff   <= uptime_in;
         busy_ff     <= busy_in;
         chk_vld_ff  <= chk_vld_in;
         hold_vld_ff <= hold_vld_in;
         found_ff    <= found_in;
         scan_idx_ff <= scan_idx_in;
         nres_ff     <= nres_in;
         mode_ff     <= mode_in;
      end
   end

   always_ff @(posedge clock) begin
      handle_ff      <= handle_in;
      period_ff      <= period_in;
      chk_idx_ff     <= chk_idx_in;
      hold_handle_ff <= hold_handle_in;
      hold_idx_ff    <= hold_idx_in;
   end

endmodule

>>> hdl/one_shot_software_timer_table_top.sv
// ----------------------------------------------------------------------------
// one_shot_software_timer_table_top
// One-shot timer table: create, delete and tick requests over a slot RAM.
//
//   channel  direction  ports                                    transfer when
//   req      in         req_mode, req_timer_handle, req_period   req_valid & req_ready
//   rsp      out        rsp_kind, rsp_accepted, rsp_handle_out,  rsp_valid & rsp_ready
//                       rsp_slot_out, rsp_last
//
// Create takes a free slot, if any, and answers. Tick and delete scan all slots
// through the single RAM read port, one slot per cycle while no result is held
// up. Stalls come only when a result cannot enter the output register.
// Synchronous reset clears busy flags, uptime and control; no clearing pass.
// ----------------------------------------------------------------------------
module one_shot_software_timer_table_top
   import ott_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_mode,
   input  logic [HANDLE_W-1:0] req_timer_handle,
   input  logic [TIME_W-1:0]   req_period,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [1:0]          rsp_kind,
   output logic                rsp_accepted,
   output logic [HANDLE_W-1:0] rsp_handle_out,
   output logic [2:0]          rsp_slot_out,
   output logic                rsp_last
);

   logic               ram_wr_en;
   logic [IDX_W-1:0]   ram_wr_addr;
   logic [ENTRY_W-1:0] ram_wr_data;
   logic               ram_rd_en;
   logic [IDX_W-1:0]   ram_rd_addr;
   logic [ENTRY_W-1:0] ram_rd_data;
   logic               push;
   rsp_type            push_rsp;
   logic               out_free;

   ott_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_timer_handle (req_timer_handle),
      .req_period       (req_period),
      .ram_wr_en        (ram_wr_en),
      .ram_wr_addr      (ram_wr_addr),
      .ram_wr_data      (ram_wr_data),
      .ram_rd_en        (ram_rd_en),
      .ram_rd_addr      (ram_rd_addr),
      .ram_rd_data      (ram_rd_data),
      .push             (push),
      .push_rsp         (push_rsp),
      .out_free         (out_free)
   );

   ott_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SLOTS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   ott_out u_out (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .push_rsp       (push_rsp),
      .out_free       (out_free),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_kind       (rsp_kind),
      .rsp_accepted   (rsp_accepted),
      .rsp_handle_out (rsp_handle_out),
      .rsp_slot_out   (rsp_slot_out),
      .rsp_last       (rsp_last)
   );

endmodule
